// ===== design/hamming_encoding_ring_buffer_macros.svh =====
// assertion macros for the hamming encoding ring buffer checker
`ifndef HAMMING_ENCODING_RING_BUFFER_MACROS_SVH
`define HAMMING_ENCODING_RING_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HEB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heb check failed");

// next-cycle implication, sampled on clk, off while in reset
`define HEB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heb check failed");

`endif

// ===== design/heb_pkg.sv =====
`default_nettype none
package heb_pkg;

	localparam int DEFAULT_RING_DEPTH = 64;
	localparam int DATA_W = 56;
	localparam int WORD_W = 64;

	// check bit masks, bit i of the word is the parity under mask i
	localparam logic [WORD_W-1:0] CHECK_MASKS [6] = '{
		64'hDAB5556AAAAAAA81,
		64'hB66CCCD999999982,
		64'h71E3C3C787878784,
		64'h0FE03FC07F807F88,
		64'h001FFFC0007FFF90,
		64'h0000003FFFFFFFA0
	};

	typedef enum logic [1:0] {
		ST_PUSHED   = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;

	// command from front to back
	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] word;
	} cmd_t;

	// data in bits 63..8, check bits 5..0 depend on data only,
	// bit 6 makes the whole word even, bit 7 stays zero
	function automatic logic [WORD_W-1:0] secded_encode(input logic [DATA_W-1:0] data);
		logic [WORD_W-1:0] w;
		w = {data, 8'h00};
		for (int i = 0; i < 6; i++) begin
			w[i] = ^(w & CHECK_MASKS[i]);
		end
		w[6] = ^w;
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== design/heb_front.sv =====
`default_nettype none
module heb_front
	import heb_pkg::*;
(
	input  wire logic              kind,
	input  wire logic [DATA_W-1:0] payload,
	output cmd_t                   cmd
);

	// classify and encode; pops carry no word
	always_comb begin
		cmd.kind = kind_t'(kind);
		cmd.word = (kind == KIND_POP) ? '0 : secded_encode(payload);
	end

endmodule
`default_nettype wire

// ===== design/heb_queue.sv =====
`default_nettype none
module heb_queue
	import heb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign do_wr     = in_valid && in_ready;
	assign do_rd     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/heb_back.sv =====
`default_nettype none
module heb_back
	import heb_pkg::*;
#(
	parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire cmd_t              cmd,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             out_status,
	output logic [WORD_W-1:0]      out_word
);

	localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [WORD_W-1:0] mem [RING_DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  wr_next;
	logic [IDX_W-1:0]  rd_next;
	back_state_t       state_q;
	back_state_t       state_d;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_free;
	logic              full;
	logic              empty;
	logic              load_out;
	status_t           status_d;
	logic [WORD_W-1:0] word_d;
	logic              mem_we;
	logic              mem_re;

	assign wr_next  = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_next  = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
	assign full     = (wr_next == rd_idx_q);
	assign empty    = (rd_idx_q == wr_idx_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		load_out  = 1'b0;
		status_d  = ST_PUSHED;
		word_d    = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_ready = 1'b1;
					if (cmd.kind == KIND_PUSH) begin
						load_out = 1'b1;
						if (full) begin
							status_d = ST_OVERFLOW;
						end else begin
							status_d = ST_PUSHED;
							mem_we   = 1'b1;
						end
					end else if (empty) begin
						load_out = 1'b1;
						status_d = ST_EMPTY;
					end else begin
						mem_re  = 1'b1;
						state_d = BK_READ;
					end
				end
			end
			BK_READ: begin
				// output register drained when the read was issued
				load_out = 1'b1;
				status_d = ST_POPPED;
				word_d   = rd_data_q;
				state_d  = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= cmd.word;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_idx_q];
		end
		if (load_out) begin
			out_status_q <= status_d;
			out_word_q   <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				wr_idx_q <= wr_next;
			end
			if (mem_re) begin
				rd_idx_q <= rd_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_word   = out_word_q;

endmodule
`default_nettype wire

// ===== design/hamming_encoding_ring_buffer.sv =====
// path: a push or failed pop passes the queue and the output register, a good pop
// also the ring memory's registered read port; throughput: one push or failed
// pop per cycle unless the output stalls; a good pop blocks the back until loaded
// reset: arst_n low clears ring indices, queue and output valid; ring is empty
// ring contents are not cleared, only written slots are ever read
`default_nettype none
module hamming_encoding_ring_buffer
	import heb_pkg::*;
#(
	parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input beat
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // payload[55:0]
	input  wire logic              s_tuser,   // kind[0]: 0 push, 1 pop
	// result beat
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [WORD_W-1:0]      m_tdata,   // stored_word[63:0]
	output logic [1:0]             m_tuser    // status[1:0]
);

	// front: classify the beat and encode push data
	cmd_t front_cmd;
	// queue to back
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	heb_front u_front (
		.kind    (s_tuser),
		.payload (s_tdata),
		.cmd     (front_cmd)
	);

	// short queue lets the front keep taking beats while the back waits on
	// a memory read or a stalled output
	heb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (front_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_cmd   (back_cmd)
	);

	// back: ring memory, read/write indices, full/empty checks, output register
	heb_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (back_valid),
		.cmd_ready  (back_ready),
		.cmd        (back_cmd),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_word   (m_tdata)
	);

endmodule
`default_nettype wire

// ===== design/heb_checker.sv =====
`default_nettype none
`include "hamming_encoding_ring_buffer_macros.svh"
module heb_checker
	import heb_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [WORD_W-1:0] m_tdata,
	input wire logic [1:0]        m_tuser
);

	// a stalled result holds
	`HEB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`HEB_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	// only a good pop carries a word
	`HEB_ASSERT_NOW(a_word_zero, m_tvalid && (m_tuser != ST_POPPED), m_tdata == '0)
	// a popped word is a valid codeword
	`HEB_ASSERT_NOW(a_codeword, m_tvalid && (m_tuser == ST_POPPED),
		m_tdata == secded_encode(m_tdata[WORD_W-1:8]))

endmodule

bind hamming_encoding_ring_buffer heb_checker u_heb_checker (.*);
`default_nettype wire

// ===== bench/heb_bench_pkg.sv =====
package heb_bench_pkg;
	import heb_pkg::*;

	localparam int RING_SLOTS = DEFAULT_RING_DEPTH;

	// parity groups of check bits 0..5, data sits in bits 63..8
	localparam logic [63:0] PARITY_GROUPS [6] = '{
		64'hDAB5556AAAAAAA81,
		64'hB66CCCD999999982,
		64'h71E3C3C787878784,
		64'h0FE03FC07F807F88,
		64'h001FFFC0007FFF90,
		64'h0000003FFFFFFFA0
	};

	typedef struct packed {
		status_t     status;
		logic [63:0] word;
	} ring_result_t;

	// check bits from data alone, then overall parity over data and checks
	function automatic logic [63:0] secded_word(input logic [55:0] data);
		logic [5:0] checks;
		logic overall;
		for (int i = 0; i < 6; i++) begin
			checks[i] = ^({data, 8'h00} & PARITY_GROUPS[i]);
		end
		overall = (^data) ^ (^checks);
		return {data, 1'b0, overall, checks};
	endfunction

	class ring_scoreboard;
		logic [63:0] slots [RING_SLOTS];
		int head;   // next slot to write
		int tail;   // oldest stored slot
		ring_result_t expected_results [$];
		int mismatches;

		function new();
			head = 0;
			tail = 0;
			mismatches = 0;
		endfunction

		// predict the result of one accepted command beat
		function void note_command(kind_t kind, logic [55:0] payload);
			ring_result_t r;
			int nxt;
			r.word = '0;
			if (kind == KIND_PUSH) begin
				nxt = (head + 1) % RING_SLOTS;
				if (nxt == tail) begin
					r.status = ST_OVERFLOW;
				end else begin
					slots[head] = secded_word(payload);
					head = nxt;
					r.status = ST_PUSHED;
				end
			end else if (tail == head) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_POPPED;
				r.word = slots[tail];
				tail = (tail + 1) % RING_SLOTS;
			end
			expected_results.push_back(r);
		endfunction

		task log_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [1:0] status, logic [63:0] word);
			ring_result_t r;
			if (expected_results.size() == 0) begin
				log_mismatch($sformatf("result beat with nothing pending, status %0d word %h",
					status, word));
			end else begin
				r = expected_results.pop_front();
				if (status !== r.status)
					log_mismatch($sformatf("status %0d, want %0d", status, r.status));
				if (word !== r.word)
					log_mismatch($sformatf("word %h, want %h", word, r.word));
			end
		endtask
	endclass

endpackage

// ===== bench/tb_top.sv =====
module tb_top;
	import heb_pkg::*;
	import heb_bench_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // payload[55:0]
	logic              s_tuser;   // kind[0]
	logic              m_tvalid;
	logic              m_tready;
	logic [WORD_W-1:0] m_tdata;   // stored_word[63:0]
	logic [1:0]        m_tuser;   // status[1:0]

	// set while no idling is wanted on either side
	bit calm;

	ring_scoreboard sb = new();

	hamming_encoding_ring_buffer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watch both sides at the rising edge, values settled since the falling edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_command(kind_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
		end
	end

	// result side: ready high with random stall bursts unless calm
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 6) == 0) begin
				stall = $urandom_range(1, 14);
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	// one command beat, held until the block takes it
	task automatic send_beat(kind_t kind, logic [DATA_W-1:0] payload);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = payload;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_input(int cycles);
		@(negedge clk);
		s_tvalid = 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// mostly random data, with zeros, ones and single-bit patterns mixed in
	function automatic logic [DATA_W-1:0] pick_payload();
		logic [63:0] raw;
		logic [DATA_W-1:0] p;
		int sel;
		raw = {$urandom(), $urandom()};
		p = raw[DATA_W-1:0];
		sel = $urandom_range(0, 11);
		case (sel)
			0: p = '0;
			1: p = '1;
			2: p = {{(DATA_W-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_W-1);
			3: p = ~({{(DATA_W-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_W-1));
			default: ;
		endcase
		return p;
	endfunction

	// push odds out of 8 per segment mode: fill, drain, mixed
	function automatic int push_odds(int mode);
		case (mode)
			0: return 7;
			1: return 1;
			default: return 4;
		endcase
	endfunction

	initial begin
		int sent;
		int seg_len;
		int mode;
		int odds;
		kind_t kind;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_PUSH;
		calm = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, data extremes, drain, empty pop again
		send_beat(KIND_POP, '1);
		send_beat(KIND_PUSH, '0);
		send_beat(KIND_PUSH, '1);
		send_beat(KIND_PUSH, 56'h80_0000_0000_0000);
		send_beat(KIND_PUSH, 56'h00_0000_0000_0001);
		send_beat(KIND_PUSH, 56'hAA_AAAA_AAAA_AAAA);
		send_beat(KIND_PUSH, 56'h55_5555_5555_5555);
		send_beat(KIND_POP, 56'h12_3456_789A_BCDE);
		send_beat(KIND_POP, '0);
		send_beat(KIND_PUSH, 56'hFF_0000_0000_00FF);
		send_beat(KIND_POP, '1);
		send_beat(KIND_POP, '0);
		send_beat(KIND_POP, '0);
		send_beat(KIND_POP, '0);
		send_beat(KIND_POP, '0);
		send_beat(KIND_POP, '0);
		send_beat(KIND_POP, '1);
		send_beat(KIND_PUSH, 56'h01_0203_0405_0607);
		send_beat(KIND_POP, '0);

		// random segments that fill, drain or mix, so full, empty and wrap recur
		sent = 0;
		while (sent < 1000) begin
			mode = $urandom_range(0, 2);
			odds = push_odds(mode);
			seg_len = $urandom_range(20, 90);
			calm = ($urandom_range(0, 3) == 0) || (sent >= 850);
			for (int j = 0; j < seg_len; j++) begin
				kind = ($urandom_range(0, 7) < odds) ? KIND_PUSH : KIND_POP;
				if (!calm && $urandom_range(0, 3) == 0)
					idle_input($urandom_range(1, 14));
				send_beat(kind, pick_payload());
				sent++;
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;

		// drain, then a few quiet cycles to catch stray beats
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
